/* rtl/tam_pkg.sv */
package tam_pkg;

  // Quaternion products are 32-bit signed (Q4.28); rotation elements need 34 bits.
  localparam int QUAT_W  = 16;
  localparam int SCALE_W = 24;
  localparam int QPROD_W = 2 * QUAT_W;
  localparam int ROT_W   = QPROD_W + 2;
  localparam int PROD_W  = ROT_W + SCALE_W;
  localparam int OUT_W   = 32;
  localparam int FRAC_ROT = 28;

  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [SCALE_W-1:0] scale_t;
  typedef logic signed [QPROD_W-1:0] qprod_t;
  typedef logic signed [ROT_W-1:0]   rot_elem_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [OUT_W-1:0]   out_t;

  // Column-major: index col * 3 + row.
  typedef rot_elem_t rot_mat_t [9];

  localparam rot_elem_t ONE_ROT    = rot_elem_t'(1) <<< FRAC_ROT;
  localparam prod_t     ROUND_HALF = prod_t'(1) <<< (FRAC_ROT - 1);
  localparam prod_t     OUT_MAX    = prod_t'(32'sh7FFF_FFFF);
  localparam prod_t     OUT_MIN    = -prod_t'(32'sh7FFF_FFFF) - prod_t'(1);

endpackage

/* rtl/trs_to_affine_matrix.sv */
// TRS to affine matrix.
// Command channel: drive one node transform (trans_*, quat_*, scale_*) and
// raise start; the item is taken at the clock edge where start is high and
// busy is low. busy is always low, so an item may be issued every cycle.
// Result channel: done is high for exactly one cycle while m_rR_cC carry the
// upper 3x4 of the column-major affine matrix; the bottom row is 0,0,0,1 and
// is not output. The receiver must take the item in that cycle.
// Throughput: one item per cycle, through the four register stages:
//   1) quaternion component products, 2) rotation elements,
//   3) rotation times axis scale (34x24 multiplier per element),
//   4) round to nearest and saturate to Q16.16.
// Translation is carried alongside and copied unchanged.
// Reset (rst, synchronous) clears every stage valid bit, dropping items in
// flight; no result appears for them. Data registers are not reset.
module trs_to_affine_matrix (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  trans_x,
  input  logic signed [31:0]  trans_y,
  input  logic signed [31:0]  trans_z,
  input  logic signed [15:0]  quat_x,
  input  logic signed [15:0]  quat_y,
  input  logic signed [15:0]  quat_z,
  input  logic signed [15:0]  quat_w,
  input  logic signed [23:0]  scale_x,
  input  logic signed [23:0]  scale_y,
  input  logic signed [23:0]  scale_z,
  output logic                done,
  output logic signed [31:0]  m_r0_c0,
  output logic signed [31:0]  m_r1_c0,
  output logic signed [31:0]  m_r2_c0,
  output logic signed [31:0]  m_r0_c1,
  output logic signed [31:0]  m_r1_c1,
  output logic signed [31:0]  m_r2_c1,
  output logic signed [31:0]  m_r0_c2,
  output logic signed [31:0]  m_r1_c2,
  output logic signed [31:0]  m_r2_c2,
  output logic signed [31:0]  m_r0_c3,
  output logic signed [31:0]  m_r1_c3,
  output logic signed [31:0]  m_r2_c3
);

  // The pipeline never stalls, so the command side is always free.
  assign busy = 1'b0;

  logic              accept;
  logic              rot_valid;
  logic              mul_valid;
  tam_pkg::rot_mat_t rot;
  tam_pkg::out_t     elem [9];

  assign accept = start && !busy;

  tam_rot_gen u_rot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .qx        (quat_x),
    .qy        (quat_y),
    .qz        (quat_z),
    .qw        (quat_w),
    .out_valid (rot_valid),
    .rot       (rot)
  );

  // Scale rides two stages to meet the rotation elements at the multipliers.
  tam_pkg::scale_t sc_d1 [3];
  tam_pkg::scale_t sc_d2 [3];

  // Translation rides all four stages to leave with its matrix.
  tam_pkg::out_t tr_d1 [3];
  tam_pkg::out_t tr_d2 [3];
  tam_pkg::out_t tr_d3 [3];
  tam_pkg::out_t tr_d4 [3];

  always_ff @(posedge clk) begin
    sc_d1[0] <= scale_x;
    sc_d1[1] <= scale_y;
    sc_d1[2] <= scale_z;
    sc_d2    <= sc_d1;
    tr_d1[0] <= trans_x;
    tr_d1[1] <= trans_y;
    tr_d1[2] <= trans_z;
    tr_d2    <= tr_d1;
    tr_d3    <= tr_d2;
    tr_d4    <= tr_d3;
  end

  // Advance the valid bits of the multiply and round stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      mul_valid <= rot_valid;
      done      <= mul_valid;
    end
  end

  // One scaling unit per rotation element; column c takes scale of axis c.
  for (genvar g = 0; g < 9; g++) begin : g_elem
    tam_scale_sat u_sat (
      .clk    (clk),
      .rot    (rot[g]),
      .scale  (sc_d2[g / 3]),
      .result (elem[g])
    );
  end

  assign m_r0_c0 = elem[0];
  assign m_r1_c0 = elem[1];
  assign m_r2_c0 = elem[2];
  assign m_r0_c1 = elem[3];
  assign m_r1_c1 = elem[4];
  assign m_r2_c1 = elem[5];
  assign m_r0_c2 = elem[6];
  assign m_r1_c2 = elem[7];
  assign m_r2_c2 = elem[8];
  assign m_r0_c3 = tr_d4[0];
  assign m_r1_c3 = tr_d4[1];
  assign m_r2_c3 = tr_d4[2];

`ifndef SYNTH
  // Every result traces back to an earlier accepted item.
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 4))
    else $error("result without an item four cycles earlier");

  // An item not cut off by reset always yields its result.
  a_item_gives_done: assert property (@(posedge clk) disable iff (rst)
    ($past(accept, 4) && !$past(rst, 4) && !$past(rst, 3) && !$past(rst, 2)
     && !$past(rst, 1)) |-> done)
    else $error("item lost in the pipeline");

  // Translation leaves aligned with the matrix built from the same item.
  a_trans_aligned: assert property (@(posedge clk) disable iff (rst)
    done |-> (m_r0_c3 == $past(trans_x, 4) && m_r1_c3 == $past(trans_y, 4)
              && m_r2_c3 == $past(trans_z, 4)))
    else $error("translation out of step with its matrix");
`endif

endmodule

/* rtl/tam_rot_gen.sv */
module tam_rot_gen (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  tam_pkg::quat_t    qx,
  input  tam_pkg::quat_t    qy,
  input  tam_pkg::quat_t    qz,
  input  tam_pkg::quat_t    qw,
  output logic              out_valid,
  output tam_pkg::rot_mat_t rot
);

  logic            prod_valid;
  tam_pkg::qprod_t p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;

  // Stage one: the nine component products.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= in_valid;
    end
    p_xx <= qx * qx;
    p_yy <= qy * qy;
    p_zz <= qz * qz;
    p_xy <= qx * qy;
    p_xz <= qx * qz;
    p_yz <= qy * qz;
    p_wx <= qw * qx;
    p_wy <= qw * qy;
    p_wz <= qw * qz;
  end

  function automatic tam_pkg::rot_elem_t twice_sum(tam_pkg::qprod_t a, tam_pkg::qprod_t b);
    tam_pkg::rot_elem_t s;
    s = tam_pkg::rot_elem_t'(a) + tam_pkg::rot_elem_t'(b);
    return s <<< 1;
  endfunction

  function automatic tam_pkg::rot_elem_t twice_diff(tam_pkg::qprod_t a, tam_pkg::qprod_t b);
    tam_pkg::rot_elem_t s;
    s = tam_pkg::rot_elem_t'(a) - tam_pkg::rot_elem_t'(b);
    return s <<< 1;
  endfunction

  // Stage two: combine products into the rotation elements.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= prod_valid;
    end
    rot[0] <= tam_pkg::ONE_ROT - twice_sum(p_yy, p_zz);
    rot[1] <= twice_sum(p_xy, p_wz);
    rot[2] <= twice_diff(p_xz, p_wy);
    rot[3] <= twice_diff(p_xy, p_wz);
    rot[4] <= tam_pkg::ONE_ROT - twice_sum(p_xx, p_zz);
    rot[5] <= twice_sum(p_yz, p_wx);
    rot[6] <= twice_sum(p_xz, p_wy);
    rot[7] <= twice_diff(p_yz, p_wx);
    rot[8] <= tam_pkg::ONE_ROT - twice_sum(p_xx, p_yy);
  end

endmodule

/* rtl/tam_scale_sat.sv */
module tam_scale_sat (
  input  logic               clk,
  input  tam_pkg::rot_elem_t rot,
  input  tam_pkg::scale_t    scale,
  output tam_pkg::out_t      result
);

  tam_pkg::prod_t prod;
  tam_pkg::prod_t rounded;
  tam_pkg::prod_t shifted;
  tam_pkg::out_t  result_next;

  // Exact product, registered before rounding.
  always_ff @(posedge clk) begin
    prod <= rot * scale;
  end

  // Round to nearest, ties upward, then clamp to the output range.
  always_comb begin
    rounded = prod + tam_pkg::ROUND_HALF;
    shifted = rounded >>> tam_pkg::FRAC_ROT;
    if (shifted > tam_pkg::OUT_MAX) begin
      result_next = tam_pkg::out_t'(tam_pkg::OUT_MAX);
    end else if (shifted < tam_pkg::OUT_MIN) begin
      result_next = tam_pkg::out_t'(tam_pkg::OUT_MIN);
    end else begin
      result_next = shifted[tam_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

/* verif/trs_to_affine_matrix_tb.sv */
module trs_to_affine_matrix_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef tam_pkg::out_t   out_t;
  typedef tam_pkg::quat_t  quat_t;
  typedef tam_pkg::scale_t scale_t;

  // One node transform as it is offered on the command side.
  typedef struct {
    out_t   tx, ty, tz;
    quat_t  qx, qy, qz, qw;
    scale_t sx, sy, sz;
  } trs_t;

  // Upper 3x4 of the affine matrix, column-major: index col * 3 + row,
  // so elements 9..11 are the translation column.
  typedef struct {
    out_t el[12];
  } matrix_t;

  // Scoreboard: turns each accepted transform into the matrix it must give
  // and compares results, oldest first, as they appear on the done strobe.
  class affine_book;
    matrix_t     due[$];
    int unsigned noted;
    int unsigned checked;
    int unsigned mismatches;
    int unsigned saturated;

    // Scale one exact rotation element (28 fractional bits), round to
    // nearest with ties upwards, then clamp to Q16.16.
    function out_t scale_round(longint rot, longint sc);
      longint p;
      longint r;
      p = rot * sc;
      r = (p + (longint'(1) <<< (tam_pkg::FRAC_ROT - 1))) >>> tam_pkg::FRAC_ROT;
      if (r > longint'(2147483647))
        r = 2147483647;
      if (r < -longint'(2147483647) - longint'(1))
        r = -longint'(2147483647) - longint'(1);
      return out_t'(r);
    endfunction

    // The quaternion is used as it stands: no normalising, so a zero
    // quaternion collapses to the identity and long ones add skew.
    function matrix_t build_matrix(trs_t t);
      longint  x, y, z, w, unit;
      longint  rot[9];
      longint  sc[3];
      matrix_t m;
      x = t.qx;
      y = t.qy;
      z = t.qz;
      w = t.qw;
      unit = longint'(1) <<< tam_pkg::FRAC_ROT;
      sc[0] = t.sx;
      sc[1] = t.sy;
      sc[2] = t.sz;
      rot[0] = unit - 2 * (y * y + z * z);
      rot[1] = 2 * (x * y + w * z);
      rot[2] = 2 * (x * z - w * y);
      rot[3] = 2 * (x * y - w * z);
      rot[4] = unit - 2 * (x * x + z * z);
      rot[5] = 2 * (y * z + w * x);
      rot[6] = 2 * (x * z + w * y);
      rot[7] = 2 * (y * z - w * x);
      rot[8] = unit - 2 * (x * x + y * y);
      for (int col = 0; col < 3; col++)
        for (int row = 0; row < 3; row++)
          m.el[col * 3 + row] = scale_round(rot[col * 3 + row], sc[col]);
      m.el[9]  = t.tx;
      m.el[10] = t.ty;
      m.el[11] = t.tz;
      return m;
    endfunction

    function void note_transform(trs_t t);
      due = {due, build_matrix(t)};
      noted++;
    endfunction

    function void check_matrix(matrix_t got);
      matrix_t want;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: matrix on done with no transform outstanding", $realtime);
        return;
      end
      want = due.pop_front();
      checked++;
      for (int i = 0; i < 12; i++) begin
        if (got.el[i] !== want.el[i]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: matrix %0d m_r%0d_c%0d expected %h got %h", $realtime,
                     checked, i % 3, i / 3, want.el[i], got.el[i]);
        end else if (i < 9 && (got.el[i] == 32'h7FFF_FFFF || got.el[i] == 32'h8000_0000)) begin
          saturated++;
        end
      end
    endfunction

    function int unsigned outstanding();
      return due.size();
    endfunction
  endclass

  localparam int unsigned RANDOM_ITEMS = 1300;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  out_t  trans_x = '0, trans_y = '0, trans_z = '0;
  quat_t quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
  scale_t scale_x = '0, scale_y = '0, scale_z = '0;
  logic  done;
  out_t  m_r0_c0, m_r1_c0, m_r2_c0;
  out_t  m_r0_c1, m_r1_c1, m_r2_c1;
  out_t  m_r0_c2, m_r1_c2, m_r2_c2;
  out_t  m_r0_c3, m_r1_c3, m_r2_c3;

  affine_book  book = new();
  matrix_t     seen;
  int unsigned sent;
  int unsigned drains;

  trs_to_affine_matrix uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .trans_x (trans_x),
    .trans_y (trans_y),
    .trans_z (trans_z),
    .quat_x  (quat_x),
    .quat_y  (quat_y),
    .quat_z  (quat_z),
    .quat_w  (quat_w),
    .scale_x (scale_x),
    .scale_y (scale_y),
    .scale_z (scale_z),
    .done    (done),
    .m_r0_c0 (m_r0_c0),
    .m_r1_c0 (m_r1_c0),
    .m_r2_c0 (m_r2_c0),
    .m_r0_c1 (m_r0_c1),
    .m_r1_c1 (m_r1_c1),
    .m_r2_c1 (m_r2_c1),
    .m_r0_c2 (m_r0_c2),
    .m_r1_c2 (m_r1_c2),
    .m_r2_c2 (m_r2_c2),
    .m_r0_c3 (m_r0_c3),
    .m_r1_c3 (m_r1_c3),
    .m_r2_c3 (m_r2_c3)
  );

  always #6 clk = ~clk;

  // Take a result at the edge that ends its done cycle. Values read here are
  // the ones held before the edge, so the order of processes does not matter.
  always @(posedge clk) begin
    if (!rst && done) begin
      seen.el[0]  = m_r0_c0;
      seen.el[1]  = m_r1_c0;
      seen.el[2]  = m_r2_c0;
      seen.el[3]  = m_r0_c1;
      seen.el[4]  = m_r1_c1;
      seen.el[5]  = m_r2_c1;
      seen.el[6]  = m_r0_c2;
      seen.el[7]  = m_r1_c2;
      seen.el[8]  = m_r2_c2;
      seen.el[9]  = m_r0_c3;
      seen.el[10] = m_r1_c3;
      seen.el[11] = m_r2_c3;
      book.check_matrix(seen);
    end
  end

  function automatic trs_t make_transform(out_t tx, out_t ty, out_t tz,
                                          quat_t qx, quat_t qy, quat_t qz, quat_t qw,
                                          scale_t sx, scale_t sy, scale_t sz);
    trs_t t;
    t.tx = tx;
    t.ty = ty;
    t.tz = tz;
    t.qx = qx;
    t.qy = qy;
    t.qz = qz;
    t.qw = qw;
    t.sx = sx;
    t.sy = sy;
    t.sz = sz;
    return t;
  endfunction

  // Scale drawn from the corners of its range most of the time.
  function automatic scale_t corner_scale();
    case ($urandom_range(0, 6))
      0: return scale_t'(24'h7F_FFFF);
      1: return scale_t'(24'h80_0000);
      2: return '0;
      3: return scale_t'(1);
      4: return scale_t'(-1);
      5: return scale_t'(24'sh01_0000);
      default: return scale_t'($urandom());
    endcase
  endfunction

  function automatic quat_t sparse_quat();
    if ($urandom_range(0, 1) == 0)
      return '0;
    return quat_t'($urandom());
  endfunction

  // Half the time plausible rotations with moderate scale; the rest roams the
  // whole field ranges or leans on zeros and extremes.
  function automatic trs_t random_transform();
    trs_t        t;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    t.tx = out_t'($urandom());
    t.ty = out_t'($urandom());
    t.tz = out_t'($urandom());
    if (mode < 5) begin
      t.qx = quat_t'(int'($urandom_range(0, 32768)) - 16384);
      t.qy = quat_t'(int'($urandom_range(0, 32768)) - 16384);
      t.qz = quat_t'(int'($urandom_range(0, 32768)) - 16384);
      t.qw = quat_t'(int'($urandom_range(0, 32768)) - 16384);
      t.sx = scale_t'(int'($urandom_range(0, 524288)) - 262144);
      t.sy = scale_t'(int'($urandom_range(0, 524288)) - 262144);
      t.sz = scale_t'(int'($urandom_range(0, 524288)) - 262144);
    end else if (mode < 8) begin
      t.qx = quat_t'($urandom());
      t.qy = quat_t'($urandom());
      t.qz = quat_t'($urandom());
      t.qw = quat_t'($urandom());
      t.sx = scale_t'($urandom());
      t.sy = scale_t'($urandom());
      t.sz = scale_t'($urandom());
    end else begin
      t.qx = sparse_quat();
      t.qy = sparse_quat();
      t.qz = sparse_quat();
      t.qw = sparse_quat();
      t.sx = corner_scale();
      t.sy = corner_scale();
      t.sz = corner_scale();
    end
    return t;
  endfunction

  // Present one transform and hold start until it is taken. start is left
  // high so that a burst runs back to back; only rest() and drain() lower it.
  task automatic issue_transform(input trs_t t);
    start   <= 1'b1;
    trans_x <= t.tx;
    trans_y <= t.ty;
    trans_z <= t.tz;
    quat_x  <= t.qx;
    quat_y  <= t.qy;
    quat_z  <= t.qz;
    quat_w  <= t.qw;
    scale_x <= t.sx;
    scale_y <= t.sy;
    scale_z <= t.sz;
    do
      @(posedge clk);
    while (busy);
    book.note_transform(t);
    sent++;
  endtask

  task automatic rest(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until the pipeline has handed back everything owed.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (book.outstanding() != 0)
      @(posedge clk);
    drains++;
  endtask

  initial begin
    trs_t        list[$];
    int unsigned burst;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Identity rotation, unit scale.
    list = {list, make_transform(0, 0, 0, 0, 0, 0, 16384, 65536, 65536, 65536)};
    // Zero quaternion falls back to identity; translation extremes ride along.
    list = {list, make_transform(32'h7FFF_FFFF, 32'h8000_0000, -1, 0, 0, 0, 0,
                                  65536, -65536, 1)};
    // Largest quaternion and scale in both signs; even these stay inside the clamp.
    list = {list, make_transform(32'h5555_5555, 32'hAAAA_AAAA, 0,
                                  16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                  24'sh7F_FFFF, 24'sh7F_FFFF, 24'sh7F_FFFF)};
    list = {list, make_transform(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF,
                                  16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                                  24'sh80_0000, 24'sh80_0000, 24'sh80_0000)};
    list = {list, make_transform(1, 2, 3, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                                  24'sh7F_FFFF, 24'sh80_0000, 24'sh7F_FFFF)};
    list = {list, make_transform(-1, -2, -3, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                                  24'sh7F_FFFF, 24'sh80_0000, 24'sh7F_FFFF)};
    // Quarter turns about x, y and z with doubled scale, then a half turn about z.
    list = {list, make_transform(65536, 0, 0, 11585, 0, 0, 11585, 131072, 131072, 131072)};
    list = {list, make_transform(0, 65536, 0, 0, 11585, 0, 11585, 131072, 131072, 131072)};
    list = {list, make_transform(0, 0, 65536, 0, 0, 11585, 11585, 131072, 131072, 131072)};
    list = {list, make_transform(0, 0, 0, 0, 0, 16384, 0, 65536, 65536, 65536)};
    // Exact halves at the rounding point: ties must go upwards.
    list = {list, make_transform(0, 0, 0, 8192, 8192, 0, 0, 1, 1, 1)};
    list = {list, make_transform(0, 0, 0, 8192, 8192, 0, 0, -1, -1, -1)};
    list = {list, make_transform(0, 0, 0, 0, 8192, 8192, 0, 1, -1, 1)};
    // Zero scale wipes the rotation whatever the quaternion.
    list = {list, make_transform(12345, -12345, 0, 16'sh7FFF, 16'sh8000, 1234, -4321,
                                  0, 0, 0)};
    // A quaternion component of -2.0 on its own, plus a mirrored scale.
    list = {list, make_transform(0, 0, 0, 16'sh8000, 0, 0, 0, 65536, 65536, 65536)};
    list = {list, make_transform(0, 0, 0, 0, 0, 0, 16384, -65536, 65536, -65536)};
    // Unnormalised but mild: skew stays in range.
    list = {list, make_transform(100, 200, 300, 3000, -7000, 9000, 20000,
                                  24'sh02_8000, 24'shFE_C000, 24'sh00_4000)};

    foreach (list[i])
      issue_transform(list[i]);
    drain();

    // Random part: bursts of random length, gaps of random length, and now
    // and then a full drain so that the pipeline empties between bursts.
    while (sent < list.size() + RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      repeat (burst)
        if (sent < list.size() + RANDOM_ITEMS)
          issue_transform(random_transform());
      case ($urandom_range(0, 9))
        0, 1, 2: ;
        9:       drain();
        default: rest($urandom_range(1, 10));
      endcase
    end

    drain();
    // Four-stage pipeline: a few more edges catch any stray done.
    repeat (8) @(posedge clk);

    $display("Covered %0d transforms (%0d directed), %0d matrices compared, %0d drains.",
             book.noted, list.size(), book.checked, drains);
    $display("Clamped rotation elements seen: %0d; mismatches: %0d.",
             book.saturated, book.mismatches);
    if (book.mismatches == 0 && book.outstanding() == 0)
      $display("[trs_to_affine_matrix] OK");
    else
      $display("[trs_to_affine_matrix] ERROR");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2ms;
    $display("Timed out with %0d matrices still owed.", book.outstanding());
    $display("[trs_to_affine_matrix] ERROR");
    $finish;
  end

endmodule
